### rtl/core/sfnv_pkg.sv
package sfnv_pkg;

  // Hash and salt widths
  localparam int unsigned HashW = 32;
  localparam int unsigned SaltW = 63;
  localparam int unsigned DigW  = 16;

  // FNV-1a 32-bit constants
  localparam logic [HashW-1:0] HashBasis = 32'h811C_9DC5;
  localparam logic [HashW-1:0] HashPrime = 32'h0100_0193;

  // Salt register value after reset
  localparam logic [SaltW-1:0] SaltReset = 63'h4E41_5449_5645_5245;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SALT,
    ST_FOLD
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic take_in;    // input transaction accepted this cycle
    logic load_salt;  // copy salt register into the salt shifter
    logic salt_step;  // absorb the top salt byte and shift
    logic finish;     // fold into the output register, restore basis
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;   // output register holds a digest not taken this cycle
  } stat_t;

endpackage

### rtl/core/sfnv_ctrl.sv
module sfnv_ctrl import sfnv_pkg::*; #(
  parameter int unsigned SALT_LEN = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_last_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam int unsigned CntW    = (SALT_LEN < 2) ? 1 : $clog2(SALT_LEN);
  localparam logic        HasSalt = (SALT_LEN > 0);
  localparam logic [CntW-1:0] CntLast = CntW'(SALT_LEN - 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;

  assign accept = in_valid_i & in_ready_o;

  // Next state and salt byte counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept && in_last_i) begin
          state_d = HasSalt ? ST_SALT : ST_FOLD;
        end
      end
      ST_SALT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (!stat_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.take_in   = in_valid_i;
        cmd_o.load_salt = in_valid_i & in_last_i;
      end
      ST_SALT: cmd_o.salt_step = 1'b1;
      ST_FOLD: cmd_o.finish    = ~stat_i.out_busy;
      default: cmd_o           = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### rtl/core/sfnv_dp.sv
module sfnv_dp import sfnv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SaltW-1:0] cfg_wdata_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_has_i,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DigW-1:0]  out_digest_o
);

  logic [HashW-1:0] hash_q, hash_d;
  logic [SaltW-1:0] salt_cfg_q;
  logic [63:0]      salt_sh_q, salt_sh_d;
  logic [DigW-1:0]  dig_q, dig_d;
  logic             out_vld_q, out_vld_d;
  logic [7:0]       byte_sel;
  logic [HashW-1:0] mix;
  logic [HashW-1:0] prod;

  // One FNV-1a round, shared by message and salt bytes
  assign byte_sel = cmd_i.salt_step ? salt_sh_q[63:56] : in_byte_i;
  assign mix      = hash_q ^ {{(HashW-8){1'b0}}, byte_sel};
  assign prod     = mix * HashPrime;

  // Running hash
  always_comb begin
    hash_d = hash_q;
    if (cmd_i.finish) begin
      hash_d = HashBasis;
    end else if (cmd_i.salt_step || (cmd_i.take_in && in_has_i)) begin
      hash_d = prod;
    end
  end

  // Salt shifter, top byte first
  always_comb begin
    salt_sh_d = salt_sh_q;
    if (cmd_i.load_salt) begin
      salt_sh_d = {1'b0, salt_cfg_q};
    end else if (cmd_i.salt_step) begin
      salt_sh_d = {salt_sh_q[55:0], 8'h00};
    end
  end

  // Output register: fold and hold until taken
  always_comb begin
    dig_d     = dig_q;
    out_vld_d = out_vld_q & ~out_ready_i;
    if (cmd_i.finish) begin
      dig_d     = hash_q[31:16] ^ hash_q[15:0];
      out_vld_d = 1'b1;
    end
  end

  assign stat_o.out_busy = out_vld_q & ~out_ready_i;
  assign out_valid_o     = out_vld_q;
  assign out_digest_o    = dig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q     <= HashBasis;
      salt_cfg_q <= SaltReset;
      out_vld_q  <= 1'b0;
    end else begin
      hash_q    <= hash_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        salt_cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    salt_sh_q <= salt_sh_d;
    dig_q     <= dig_d;
  end

endmodule

### rtl/core/salted_fnv1a_fold16_hash.sv
// Salted FNV-1a hash folded to 16 bits. Each message byte is absorbed into a
// 32-bit FNV-1a hash in the cycle its transaction is accepted, so ordinary
// bytes stream at one per clock. The transaction marked tlast (with or
// without a byte, as tuser says) starts a tail: a salt phase that pushes
// SALT_LEN bytes of the salt register, top byte first, through the same
// single multiplier, then a fold step that folds the hash (upper half XOR
// lower half) into the output register and restores the offset basis.
// Input is refused during the tail, and the fold waits only if the previous
// digest has not been taken yet. The salt register may be written only while
// no message is in flight.
module salted_fnv1a_fold16_hash import sfnv_pkg::*; #(
  parameter int unsigned SALT_LEN = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Salt register write
  input  logic             cfg_we_i,
  input  logic [SaltW-1:0] cfg_wdata_i,
  // Message bytes
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] data_byte
  input  logic             s_axis_tuser,   // [0] has_byte
  input  logic             s_axis_tlast,   // last_byte
  // Digests
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [DigW-1:0]  m_axis_tdata    // [15:0] digest
);

  cmd_t  cmd;
  stat_t stat;

  sfnv_ctrl #(
    .SALT_LEN (SALT_LEN)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sfnv_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_byte_i    (s_axis_tdata),
    .in_has_i     (s_axis_tuser),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_digest_o (m_axis_tdata)
  );

endmodule

### rtl/core/sfnv_chk.sv
module sfnv_chk import sfnv_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             s_axis_tlast,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [DigW-1:0]  m_axis_tdata
);

  logic in_hs;
  assign in_hs = s_axis_tvalid & s_axis_tready;

  // A stalled digest holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("digest changed while stalled");

  // End of message starts the salt tail, which refuses input
  a_tail_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_hs && s_axis_tlast |=> !s_axis_tready)
    else $error("input accepted right after end of message");

  // A byte in mid-message never produces a digest on its own
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_hs && !s_axis_tlast |=> !$rose(m_axis_tvalid))
    else $error("digest appeared after a non-final byte");

  // A new digest only comes out of the fold step, when input was held off
  a_out_after_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("digest appeared without a salt and fold tail");

endmodule

bind salted_fnv1a_fold16_hash sfnv_chk u_sfnv_chk (.*);
